// ===== hw/rtl/sexpr_pkg.sv =====
package sexpr_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_CMT_NL  = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    EV_SYM_BYTE = 3'd0,
    EV_STR_BYTE = 3'd1,
    EV_SYM_END  = 3'd2,
    EV_STR_END  = 3'd3,
    EV_OPEN     = 3'd4,
    EV_CLOSE    = 3'd5,
    EV_EOS      = 3'd6
  } ev_t;

  typedef struct packed {
    ev_t        ev;
    logic [7:0] data;
    logic       num;
    logic       last;
  } res_t;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

endpackage

// ===== hw/rtl/sexpr_tokenizer.sv =====
// Channel | Dir | Ports                                                | Handshake
// in      | in  | in_char_byte, in_end_of_input                        | in_valid / in_stall
// out     | out | out_event_res, out_data_byte, out_is_numeric, out_last | out_valid / out_stall
//
// A request is decoded in the cycle it is accepted; its results appear in the next cycle.
// Up to two results per request sit in a two-entry result queue; the head drives out_*.
// A request is taken when the queue is empty, or holds one result leaving this cycle:
// one request per cycle while out_stall is low and each request gives at most one result.
// rst_n (synchronous, active low) returns the lexer to idle and empties the queue.
// in_stall follows out_stall combinationally when one result is waiting.
module sexpr_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_res,
  output logic [7:0] out_data_byte,
  output logic       out_is_numeric,
  output logic       out_last
);

  sexpr_pkg::mode_t mode_r, mode_nxt;
  logic       sym_open_r, sym_open_nxt;
  logic [1:0] sym_len_r, sym_len_nxt;
  logic       first_hash_r, first_hash_nxt;
  logic       first_minus_r, first_minus_nxt;
  logic       dot_seen_r, dot_seen_nxt;
  logic       sym_gen_r, sym_gen_nxt;

  sexpr_pkg::res_t e0_r, e0_nxt, e1_r, e1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  sexpr_pkg::res_t r0, r1;
  logic [1:0] nres;
  logic       in_fire, out_fire;
  logic [7:0] c;
  logic       is_nl, is_sp, is_digit, do_normal, sym_num;

  assign out_valid      = (cnt_r != 2'd0);
  assign out_fire       = out_valid && !out_stall;
  assign in_stall       = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && out_stall);
  assign in_fire        = in_valid && !in_stall;
  assign out_event_res  = e0_r.ev;
  assign out_data_byte  = e0_r.data;
  assign out_is_numeric = e0_r.num;
  assign out_last       = e0_r.last;

  assign c        = in_char_byte;
  assign is_nl    = (c == sexpr_pkg::CH_LF) || (c == sexpr_pkg::CH_CR);
  assign is_sp    = is_nl || (c == sexpr_pkg::CH_SPACE) || (c == sexpr_pkg::CH_TAB);
  assign is_digit = (c >= sexpr_pkg::CH_ZERO) && (c <= sexpr_pkg::CH_NINE);
  assign sym_num  = ((sym_len_r == 2'd2) && first_hash_r) ? 1'b1 :
                    (sym_gen_r || (first_minus_r && (sym_len_r == 2'd1))) ? 1'b0 : 1'b1;

  always_comb begin
    mode_nxt        = mode_r;
    sym_open_nxt    = sym_open_r;
    sym_len_nxt     = sym_len_r;
    first_hash_nxt  = first_hash_r;
    first_minus_nxt = first_minus_r;
    dot_seen_nxt    = dot_seen_r;
    sym_gen_nxt     = sym_gen_r;
    r0.ev   = sexpr_pkg::EV_EOS;
    r0.data = 8'd0;
    r0.num  = 1'b0;
    r0.last = 1'b0;
    r1.ev   = sexpr_pkg::EV_EOS;
    r1.data = 8'd0;
    r1.num  = 1'b0;
    r1.last = 1'b1;
    nres      = 2'd0;
    do_normal = 1'b0;

    if (in_end_of_input) begin
      if ((mode_r == sexpr_pkg::MODE_STRING) || (mode_r == sexpr_pkg::MODE_ESCAPE)) begin
        r0.ev = sexpr_pkg::EV_STR_END;
        nres  = 2'd2;
      end else if (sym_open_r) begin
        r0.ev  = sexpr_pkg::EV_SYM_END;
        r0.num = sym_num;
        nres   = 2'd2;
      end else begin
        nres = 2'd1;
      end
      mode_nxt        = sexpr_pkg::MODE_IDLE;
      sym_open_nxt    = 1'b0;
      sym_len_nxt     = 2'd0;
      first_hash_nxt  = 1'b0;
      first_minus_nxt = 1'b0;
      dot_seen_nxt    = 1'b0;
      sym_gen_nxt     = 1'b0;
    end else begin
      case (mode_r)
        sexpr_pkg::MODE_COMMENT: begin
          if (is_nl) begin
            mode_nxt = sexpr_pkg::MODE_CMT_NL;
          end
        end
        sexpr_pkg::MODE_CMT_NL: begin
          do_normal = !is_nl;
        end
        sexpr_pkg::MODE_STRING: begin
          if (c == sexpr_pkg::CH_QUOTE) begin
            r0.ev    = sexpr_pkg::EV_STR_END;
            nres     = 2'd1;
            mode_nxt = sexpr_pkg::MODE_IDLE;
          end else if (c == sexpr_pkg::CH_BSLASH) begin
            mode_nxt = sexpr_pkg::MODE_ESCAPE;
          end else begin
            r0.ev   = sexpr_pkg::EV_STR_BYTE;
            r0.data = c;
            nres    = 2'd1;
          end
        end
        sexpr_pkg::MODE_ESCAPE: begin
          r0.ev    = sexpr_pkg::EV_STR_BYTE;
          r0.data  = c;
          nres     = 2'd1;
          mode_nxt = sexpr_pkg::MODE_STRING;
        end
        default: begin
          do_normal = 1'b1;
        end
      endcase

      if (do_normal) begin
        mode_nxt = sexpr_pkg::MODE_IDLE;
        if (is_sp || (c == sexpr_pkg::CH_LPAREN) || (c == sexpr_pkg::CH_RPAREN) ||
            (c == sexpr_pkg::CH_QUOTE)) begin
          // these all end an open symbol first
          if (sym_open_r) begin
            r0.ev  = sexpr_pkg::EV_SYM_END;
            r0.num = sym_num;
            nres   = 2'd1;
          end
          sym_open_nxt    = 1'b0;
          sym_len_nxt     = 2'd0;
          first_hash_nxt  = 1'b0;
          first_minus_nxt = 1'b0;
          dot_seen_nxt    = 1'b0;
          sym_gen_nxt     = 1'b0;
          if ((c == sexpr_pkg::CH_LPAREN) || (c == sexpr_pkg::CH_RPAREN)) begin
            if (sym_open_r) begin
              r1.ev = (c == sexpr_pkg::CH_LPAREN) ? sexpr_pkg::EV_OPEN : sexpr_pkg::EV_CLOSE;
              nres  = 2'd2;
            end else begin
              r0.ev = (c == sexpr_pkg::CH_LPAREN) ? sexpr_pkg::EV_OPEN : sexpr_pkg::EV_CLOSE;
              nres  = 2'd1;
            end
          end
          if (c == sexpr_pkg::CH_QUOTE) begin
            mode_nxt = sexpr_pkg::MODE_STRING;
          end
        end else if (c == sexpr_pkg::CH_SEMI) begin
          mode_nxt = sexpr_pkg::MODE_COMMENT;
        end else begin
          r0.ev   = sexpr_pkg::EV_SYM_BYTE;
          r0.data = c;
          nres    = 2'd1;
          sym_open_nxt = 1'b1;
          if (!sym_open_r) begin
            sym_len_nxt     = 2'd1;
            first_hash_nxt  = (c == sexpr_pkg::CH_HASH);
            first_minus_nxt = (c == sexpr_pkg::CH_MINUS);
            dot_seen_nxt    = (c == sexpr_pkg::CH_DOT);
            sym_gen_nxt     = !is_digit && (c != sexpr_pkg::CH_DOT) &&
                              (c != sexpr_pkg::CH_MINUS);
          end else begin
            if (sym_len_r != 2'd2) begin
              sym_len_nxt = sym_len_r + 2'd1;
            end
            if (c == sexpr_pkg::CH_DOT) begin
              dot_seen_nxt = 1'b1;
              sym_gen_nxt  = sym_gen_r || dot_seen_r;
            end else if (!is_digit) begin
              sym_gen_nxt = 1'b1;
            end
          end
        end
      end
    end
    r0.last = (nres == 2'd1);
  end

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    if (in_fire) begin
      // queue is empty once the head leaves, so results load from the front
      e0_nxt  = r0;
      e1_nxt  = r1;
      cnt_nxt = nres;
    end else if (out_fire) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= sexpr_pkg::MODE_IDLE;
      sym_open_r    <= 1'b0;
      sym_len_r     <= 2'd0;
      first_hash_r  <= 1'b0;
      first_minus_r <= 1'b0;
      dot_seen_r    <= 1'b0;
      sym_gen_r     <= 1'b0;
      cnt_r         <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_r        <= mode_nxt;
        sym_open_r    <= sym_open_nxt;
        sym_len_r     <= sym_len_nxt;
        first_hash_r  <= first_hash_nxt;
        first_minus_r <= first_minus_nxt;
        dot_seen_r    <= dot_seen_nxt;
        sym_gen_r     <= sym_gen_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_not_last_has_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (cnt_r == 2'd2))
    else $error("non-final result without a queued follower");

  a_full_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> in_stall)
    else $error("request taken while result queue full");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res != sexpr_pkg::EV_SYM_BYTE) &&
     (out_event_res != sexpr_pkg::EV_STR_BYTE)) |-> (out_data_byte == 8'd0))
    else $error("data byte set on a non-byte event");

  a_num_only_sym_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_numeric) |-> (out_event_res == sexpr_pkg::EV_SYM_END))
    else $error("numeric flag on a non symbol-end event");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_byte = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_event_res;
  logic [7:0] out_data_byte;
  logic       out_is_numeric;
  logic       out_last;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_mismatch = 0;
  int tokens_fed = 0;

  sexpr_pkg::res_t pending_events[$];
  sexpr_pkg::res_t step_events[$];

  // lexer shadow state
  sexpr_pkg::mode_t tok_mode;
  logic       sym_active;
  logic [1:0] sym_len;
  logic       lead_hash;
  logic       lead_minus;
  logic       has_dot;
  logic       not_number;

  always #10 clk = ~clk;

  sexpr_tokenizer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_byte   (in_char_byte),
    .in_end_of_input(in_end_of_input),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_data_byte  (out_data_byte),
    .out_is_numeric (out_is_numeric),
    .out_last       (out_last)
  );

  function automatic bit is_eol(input logic [7:0] c);
    return c == sexpr_pkg::CH_LF || c == sexpr_pkg::CH_CR;
  endfunction

  function void emit(input sexpr_pkg::ev_t ev, input logic [7:0] d, input logic n);
    sexpr_pkg::res_t r;
    r.ev = ev;
    r.data = d;
    r.num = n;
    r.last = 1'b0;
    step_events.push_back(r);
  endfunction

  function void clear_symbol();
    sym_active = 1'b0;
    sym_len = 2'd0;
    lead_hash = 1'b0;
    lead_minus = 1'b0;
    has_dot = 1'b0;
    not_number = 1'b0;
  endfunction

  function void end_symbol();
    logic numeric;
    if (sym_active) begin
      if (sym_len >= 2'd2 && lead_hash)
        numeric = 1'b1;
      else
        numeric = !(not_number || (lead_minus && sym_len == 2'd1));
      emit(sexpr_pkg::EV_SYM_END, 8'h00, numeric);
      clear_symbol();
    end
  endfunction

  function void plain_char(input logic [7:0] c);
    bit first;
    tok_mode = sexpr_pkg::MODE_IDLE;
    if (is_eol(c) || c == sexpr_pkg::CH_SPACE || c == sexpr_pkg::CH_TAB) begin
      end_symbol();
    end else if (c == sexpr_pkg::CH_LPAREN || c == sexpr_pkg::CH_RPAREN) begin
      end_symbol();
      emit(c == sexpr_pkg::CH_LPAREN ? sexpr_pkg::EV_OPEN : sexpr_pkg::EV_CLOSE,
           8'h00, 1'b0);
    end else if (c == sexpr_pkg::CH_SEMI) begin
      tok_mode = sexpr_pkg::MODE_COMMENT;
    end else if (c == sexpr_pkg::CH_QUOTE) begin
      end_symbol();
      tok_mode = sexpr_pkg::MODE_STRING;
    end else begin
      first = !sym_active;
      if (first) begin
        sym_active = 1'b1;
        sym_len = 2'd1;
        lead_hash = (c == sexpr_pkg::CH_HASH);
        lead_minus = (c == sexpr_pkg::CH_MINUS);
      end else if (sym_len < 2'd2) begin
        sym_len = sym_len + 2'd1;
      end
      if (!(first && c == sexpr_pkg::CH_MINUS)) begin
        if (c == sexpr_pkg::CH_DOT) begin
          if (has_dot)
            not_number = 1'b1;
          else
            has_dot = 1'b1;
        end else if (c < sexpr_pkg::CH_ZERO || c > sexpr_pkg::CH_NINE) begin
          not_number = 1'b1;
        end
      end
      emit(sexpr_pkg::EV_SYM_BYTE, c, 1'b0);
    end
  endfunction

  function int tokenize_char(input logic [7:0] c, input logic eoi);
    step_events.delete();
    if (eoi) begin
      if (tok_mode == sexpr_pkg::MODE_STRING || tok_mode == sexpr_pkg::MODE_ESCAPE)
        emit(sexpr_pkg::EV_STR_END, 8'h00, 1'b0);
      else
        end_symbol();
      emit(sexpr_pkg::EV_EOS, 8'h00, 1'b0);
      tok_mode = sexpr_pkg::MODE_IDLE;
      clear_symbol();
    end else begin
      case (tok_mode)
        sexpr_pkg::MODE_COMMENT: begin
          if (is_eol(c))
            tok_mode = sexpr_pkg::MODE_CMT_NL;
        end
        sexpr_pkg::MODE_CMT_NL: begin
          if (!is_eol(c))
            plain_char(c);
        end
        sexpr_pkg::MODE_STRING: begin
          if (c == sexpr_pkg::CH_QUOTE) begin
            emit(sexpr_pkg::EV_STR_END, 8'h00, 1'b0);
            tok_mode = sexpr_pkg::MODE_IDLE;
          end else if (c == sexpr_pkg::CH_BSLASH) begin
            tok_mode = sexpr_pkg::MODE_ESCAPE;
          end else begin
            emit(sexpr_pkg::EV_STR_BYTE, c, 1'b0);
          end
        end
        sexpr_pkg::MODE_ESCAPE: begin
          emit(sexpr_pkg::EV_STR_BYTE, c, 1'b0);
          tok_mode = sexpr_pkg::MODE_STRING;
        end
        default: plain_char(c);
      endcase
    end
    if (step_events.size() > 0)
      step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i])
      pending_events.push_back(step_events[i]);
    return step_events.size();
  endfunction

  task automatic send_item(input logic [7:0] c, input logic eoi);
    int n;
    bit in_comment;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    in_comment = (tok_mode == sexpr_pkg::MODE_COMMENT || tok_mode == sexpr_pkg::MODE_CMT_NL);
    n = tokenize_char(c, eoi);
    if (n > 0 || !in_comment)
      tokens_fed++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0)
      @(negedge clk);
  endtask

  always @(negedge clk)
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  always @(posedge clk) begin : result_check
    sexpr_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: ev %0d data %02h num %0b last %0b",
                   out_event_res, out_data_byte, out_is_numeric, out_last);
      end else begin
        want = pending_events.pop_front();
        if (out_event_res !== want.ev || out_data_byte !== want.data ||
            out_is_numeric !== want.num || out_last !== want.last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected ev %0d data %02h num %0b last %0b, ",
                     want.ev, want.data, want.num, want.last,
                     "got ev %0d data %02h num %0b last %0b",
                     out_event_res, out_data_byte, out_is_numeric, out_last);
        end
      end
    end
  end

  task automatic test_symbol_classes();
    send_item(sexpr_pkg::CH_MINUS, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    send_item(sexpr_pkg::CH_DOT, 1'b0);
    send_item(sexpr_pkg::CH_SPACE, 1'b0);
    send_item(sexpr_pkg::CH_HASH, 1'b0);
    send_item("a", 1'b0);
    send_item(sexpr_pkg::CH_LPAREN, 1'b0);
  endtask

  task automatic test_strings();
    send_item("1", 1'b0);
    send_item(sexpr_pkg::CH_QUOTE, 1'b0);
    send_item(sexpr_pkg::CH_BSLASH, 1'b0);
    send_item(sexpr_pkg::CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(sexpr_pkg::CH_QUOTE, 1'b0);
    send_item(sexpr_pkg::CH_QUOTE, 1'b0);
    send_item(sexpr_pkg::CH_QUOTE, 1'b0);
  endtask

  task automatic test_comments();
    send_item("a", 1'b0);
    send_item(sexpr_pkg::CH_SEMI, 1'b0);
    send_item("z", 1'b0);
    send_item(sexpr_pkg::CH_LF, 1'b0);
    send_item(sexpr_pkg::CH_CR, 1'b0);
    send_item("b", 1'b0);
    send_item(sexpr_pkg::CH_RPAREN, 1'b0);
  endtask

  task automatic test_end_of_input();
    send_item(sexpr_pkg::CH_QUOTE, 1'b0);
    send_item("q", 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_stream(input int count, input int s_pct, input int r_pct);
    int stop_at;
    int len;
    int pick;
    logic [7:0] c;
    bit drained;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = tokens_fed + count;
    drained = 1'b0;
    while (tokens_fed < stop_at) begin
      if (!drained && tokens_fed >= stop_at - count / 2) begin
        wait_all_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 7))
            0, 1, 2, 3: c = sexpr_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            4: c = sexpr_pkg::CH_DOT;
            5: c = sexpr_pkg::CH_MINUS;
            6: c = sexpr_pkg::CH_HASH;
            default: c = 8'($urandom_range(33, 126));
          endcase
          send_item(c, 1'b0);
        end
      end else if (pick < 55) begin
        case ($urandom_range(0, 3))
          0: c = sexpr_pkg::CH_SPACE;
          1: c = sexpr_pkg::CH_TAB;
          2: c = sexpr_pkg::CH_LF;
          default: c = sexpr_pkg::CH_CR;
        endcase
        send_item(c, 1'b0);
      end else if (pick < 70) begin
        send_item($urandom_range(0, 1) ? sexpr_pkg::CH_LPAREN : sexpr_pkg::CH_RPAREN, 1'b0);
      end else if (pick < 82) begin
        send_item(sexpr_pkg::CH_QUOTE, 1'b0);
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          c = 8'($urandom_range(0, 255));
          if (c == sexpr_pkg::CH_QUOTE || c == sexpr_pkg::CH_BSLASH ||
              $urandom_range(0, 7) == 0)
            send_item(sexpr_pkg::CH_BSLASH, 1'b0);
          send_item(c, 1'b0);
        end
        // occasionally leave the string open
        if ($urandom_range(0, 9) != 0)
          send_item(sexpr_pkg::CH_QUOTE, 1'b0);
      end else if (pick < 90) begin
        send_item(sexpr_pkg::CH_SEMI, 1'b0);
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) begin
          c = 8'($urandom_range(0, 255));
          if (is_eol(c))
            c = "x";
          send_item(c, 1'b0);
        end
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          send_item($urandom_range(0, 1) ? sexpr_pkg::CH_LF : sexpr_pkg::CH_CR, 1'b0);
      end else if (pick < 95) begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    tok_mode = sexpr_pkg::MODE_IDLE;
    clear_symbol();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_symbol_classes();
    test_strings();
    test_comments();
    test_end_of_input();
    test_random_stream(400, 17, 53);
    test_random_stream(400, 53, 17);
    test_random_stream(400, 0, 0);
    wait_all_results();
    repeat (10) @(posedge clk);
    if (n_mismatch == 0 && pending_events.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
